FILE: src/background_and_color_mask_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the background and color mask unit
// Implication checks on the unit's internal control, sampled on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BACKGROUND_AND_COLOR_MASK_UNIT_DEFINES_SVH
`define BACKGROUND_AND_COLOR_MASK_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BCM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bcm: same-cycle check failed");
// next-cycle implication
`define BCM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bcm: next-cycle check failed");
`else
`define BCM_ASSERT_IMP(lbl, ante, cons)
`define BCM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: src/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared types, codes and helpers of the background and color mask unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bcm_pkg;

	typedef logic [7:0] chan_t;
	typedef chan_t [2:0] rgb_t;

	typedef struct packed {
		rgb_t       target;
		chan_t      margin;
		logic [6:0] percent;
	} cfg_t;

	typedef struct packed {
		logic en;
		logic frame_start;
	} scan_ctl_t;

	localparam logic KIND_SCAN     = 1'b0;
	localparam logic KIND_CLASSIFY = 1'b1;

	localparam logic [1:0] REG_TARGET  = 2'd0;
	localparam logic [1:0] REG_MARGIN  = 2'd1;
	localparam logic [1:0] REG_PERCENT = 2'd2;

	localparam logic [23:0] TARGET_RST  = 24'd0;
	localparam chan_t       MARGIN_RST  = 8'd20;
	localparam logic [6:0]  PERCENT_RST = 7'd30;
	localparam chan_t       CHAN_MAX    = 8'd255;

	function automatic chan_t absdiff(input chan_t a, input chan_t b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

FILE: src/background_and_color_mask_unit.sv
// ----------------------------------------------------------------------------
// background_and_color_mask_unit
// Color segmentation with background subtraction, one pixel word per clock unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//  - Configure target color, band margin and match percent over the APB port
//    (offsets 0x0, 0x4, 0x8) while no word is in flight.
//  - Stream the frame once with tuser.kind = scan; frame_start on the first
//    scan word makes it compare against white in place of the kept closest
//    color. Scan words give no output word.
//  - Stream the frame again with kind = classify, pixel and background in
//    tdata; each classify word yields one mask word on the master side.
//  - A classify word passes through the input register and then the output
//    register to m_tvalid. One word is accepted every clock unless stalled;
//    the rate is set by the single input register and the output one behind it.
//  - When the receiver stalls, the mask word holds in the output register and
//    the input register takes one more word; further words wait on s_tready.
//    Scan words keep flowing unless a classify word is parked ahead of them.
//  - Reset clears both valid flags, sets the closest color to white and the
//    registers to target 0, margin 20, percent 30.
// ----------------------------------------------------------------------------
`default_nettype none

module background_and_color_mask_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// pixel_c0, pixel_c1, pixel_c2, bg_c0, bg_c1, bg_c2
	input  wire logic [47:0] s_tdata,
	// kind, frame_start
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// mask_white, zero fill
	output logic [7:0]       m_tdata,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import bcm_pkg::*;

	`include "background_and_color_mask_unit_defines.svh"

	cfg_t      cfg;
	scan_ctl_t scan_ctl;
	rgb_t      closest;
	logic      v_s1;
	logic      kind_s1;
	logic      fs_s1;
	rgb_t      px_s1;
	rgb_t      bg_s1;
	logic      s1_go;
	logic      out_load;
	logic      mask;
	logic      out_v_q;
	logic      mask_q;

	bcm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// advance when a scan word, or when the output register is free
	assign s1_go    = v_s1 && ((kind_s1 == KIND_SCAN) || !out_v_q || m_tready);
	assign s_tready = !v_s1 || s1_go;
	assign out_load = s1_go && (kind_s1 == KIND_CLASSIFY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser[0];
			fs_s1   <= s_tuser[1];
			px_s1   <= s_tdata[23:0];
			bg_s1   <= s_tdata[47:24];
		end
	end

	assign scan_ctl.en          = s1_go && (kind_s1 == KIND_SCAN);
	assign scan_ctl.frame_start = fs_s1;

	bcm_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.px      (px_s1),
		.target  (cfg.target),
		.closest (closest)
	);

	bcm_classify u_classify (
		.px         (px_s1),
		.bg         (bg_s1),
		.closest    (closest),
		.cfg        (cfg),
		.mask_white (mask)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			mask_q <= mask;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'd0, mask_q};

	`BCM_ASSERT_IMP(a_stall_cause, !s_tready, v_s1 && kind_s1 && out_v_q && !m_tready)
	`BCM_ASSERT_IMP(a_out_from_classify, $rose(out_v_q), $past(out_load))
	`BCM_ASSERT_NXT(a_closest_hold, !scan_ctl.en, $stable(closest))
	`BCM_ASSERT_NXT(a_frame_restart, scan_ctl.en && fs_s1, (closest == {3{CHAN_MAX}}) || (closest == $past(px_s1)))

endmodule

`default_nettype wire

FILE: src/bcm_regs.sv
// ----------------------------------------------------------------------------
// bcm_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	output bcm_pkg::cfg_t     cfg
);
	import bcm_pkg::*;

	logic [1:0] idx;
	logic       wr;
	rgb_t       target_q;
	chan_t      margin_q;
	logic [6:0] percent_q;

	assign idx    = paddr[3:2];
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= TARGET_RST;
			margin_q  <= MARGIN_RST;
			percent_q <= PERCENT_RST;
		end else if (wr) begin
			unique case (idx)
				REG_TARGET:  target_q  <= pwdata[23:0];
				REG_MARGIN:  margin_q  <= pwdata[7:0];
				REG_PERCENT: percent_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TARGET:  prdata = {8'd0, target_q};
			REG_MARGIN:  prdata = {24'd0, margin_q};
			REG_PERCENT: prdata = {25'd0, percent_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign cfg.target  = target_q;
	assign cfg.margin  = margin_q;
	assign cfg.percent = percent_q;

endmodule

`default_nettype wire

FILE: src/bcm_scan.sv
// ----------------------------------------------------------------------------
// bcm_scan
// Keeps the color closest to the target, updated by scan words.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bcm_pkg::scan_ctl_t ctl,
	input  wire bcm_pkg::rgb_t     px,
	input  wire bcm_pkg::rgb_t     target,
	output bcm_pkg::rgb_t          closest
);
	import bcm_pkg::*;

	rgb_t       closest_q;
	rgb_t       kept;
	logic [2:0] nearer;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			// frame start compares against white
			kept[k]   = ctl.frame_start ? CHAN_MAX : closest_q[k];
			nearer[k] = absdiff(target[k], px[k]) < absdiff(kept[k], target[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closest_q <= {3{CHAN_MAX}};
		end else if (ctl.en) begin
			closest_q <= (&nearer) ? px : kept;
		end
	end

	assign closest = closest_q;

endmodule

`default_nettype wire

FILE: src/bcm_classify.sv
// ----------------------------------------------------------------------------
// bcm_classify
// Background band test and closest-color match for one classify word.
// ----------------------------------------------------------------------------
`default_nettype none

module bcm_classify (
	input  wire bcm_pkg::rgb_t  px,
	input  wire bcm_pkg::rgb_t  bg,
	input  wire bcm_pkg::rgb_t  closest,
	input  wire bcm_pkg::cfg_t  cfg,
	output logic                mask_white
);
	import bcm_pkg::*;

	logic [8:0]  hi_sum [3];
	chan_t       hi     [3];
	chan_t       lo     [3];
	logic [8:0]  d_inc  [3];
	logic [15:0] need   [3];
	logic [14:0] prod   [3];
	logic [2:0]  in_band;
	logic [2:0]  match;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			hi_sum[k] = {1'b0, bg[k]} + {1'b0, cfg.margin};
			hi[k]     = hi_sum[k][8] ? CHAN_MAX : hi_sum[k][7:0];
			lo[k]     = (bg[k] >= cfg.margin) ? (bg[k] - cfg.margin) : 8'd0;
			in_band[k] = (px[k] < hi[k]) && (px[k] > lo[k]);
			// d < floor(c*p/100)  <=>  100*(d+1) <= c*p
			d_inc[k] = {1'b0, absdiff(closest[k], px[k])} + 9'd1;
			need[k]  = ({7'd0, d_inc[k]} << 6) + ({7'd0, d_inc[k]} << 5)
				+ ({7'd0, d_inc[k]} << 2);
			prod[k]  = {7'd0, closest[k]} * {8'd0, cfg.percent};
			match[k] = need[k] <= {1'b0, prod[k]};
		end
	end

	assign mask_white = !(&in_band) && (&match);

endmodule

`default_nettype wire

FILE: dv/background_and_color_mask_unit_tb.sv
// ----------------------------------------------------------------------------
// background_and_color_mask_unit_tb
// Self-checking bench for the mask unit. A short table of directed pixel words
// runs under the reset registers. Random frames follow, each streamed as a
// scan pass and then a classify pass, under several register settings. Mask
// words of typed rows are checked against the table, the rest against a
// model of closest color and background band. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module background_and_color_mask_unit_tb;

	import bcm_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic  kind;
		logic  fs;
		rgb_t  px;
		rgb_t  bg;
		bit    typed;
		logic  mask;
	} pixel_row_t;

	// channel order in the hex literals is c2 c1 c0
	pixel_row_t pixel_rows [19] = '{
		'{KIND_CLASSIFY, 1'b0, 24'hFFFFFF, 24'h000000, 1'b1, 1'b1},
		'{KIND_CLASSIFY, 1'b0, 24'h000000, 24'h000000, 1'b1, 1'b0},
		'{KIND_CLASSIFY, 1'b0, 24'h0A0A0A, 24'h0A0A0A, 1'b1, 1'b0},
		'{KIND_CLASSIFY, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1},
		'{KIND_CLASSIFY, 1'b0, 24'h010101, 24'h000000, 1'b1, 1'b0},
		'{KIND_SCAN,     1'b1, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0},
		'{KIND_CLASSIFY, 1'b0, 24'h000000, 24'h808080, 1'b1, 1'b0},
		'{KIND_SCAN,     1'b1, 24'hFFFFFF, 24'h000000, 1'b0, 1'b0},
		'{KIND_CLASSIFY, 1'b0, 24'hFFFFFF, 24'h000000, 1'b1, 1'b1},
		'{KIND_SCAN,     1'b0, 24'h32C864, 24'h5A5A5A, 1'b0, 1'b0},
		'{KIND_SCAN,     1'b0, 24'h320A64, 24'hFFFFFF, 1'b0, 1'b0},
		'{KIND_SCAN,     1'b0, 24'h31C763, 24'h000000, 1'b0, 1'b0},
		'{KIND_CLASSIFY, 1'b0, 24'h31C763, 24'hFF0080, 1'b0, 1'b0},
		'{KIND_CLASSIFY, 1'b0, 24'hFEFEFE, 24'hFFFFFF, 1'b0, 1'b0},
		'{KIND_CLASSIFY, 1'b1, 24'h3CD070, 24'h31C763, 1'b0, 1'b0},
		'{KIND_SCAN,     1'b0, 24'h00FF00, 24'h123456, 1'b0, 1'b0},
		'{KIND_CLASSIFY, 1'b0, 24'h000000, 24'hFFFFFF, 1'b0, 1'b0},
		'{KIND_SCAN,     1'b1, 24'h00FF00, 24'h000000, 1'b0, 1'b0},
		'{KIND_CLASSIFY, 1'b0, 24'hF0F0F0, 24'h101010, 1'b0, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// model state and registers
	rgb_t       kept_color;
	rgb_t       cfg_target;
	chan_t      cfg_margin;
	logic [6:0] cfg_percent;

	logic mask_q [$];
	logic mask_want;
	int   mismatches = 0;
	int   words_sent = 0;
	int   tx_idle_pct = 0;
	int   rx_idle_pct = 0;
	int   rx_stall = 0;

	background_and_color_mask_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("== FAIL ==");
		$finish;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (mismatches < 40)
			$display("mismatch: %s got %0d want %0d", what, got, want);
		mismatches++;
	endtask

	function automatic int chan_dist(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Advance the model by one word; return 1 when a mask word is due.
	function automatic bit predict_mask(input logic kind, input logic fs, input rgb_t px,
			input rgb_t bg, output logic mask);
		int  k, hi, lo, lim, t;
		bit  nearer, in_band, match;
		mask = 1'b0;
		if (kind == KIND_SCAN) begin
			nearer = 1'b1;
			if (fs)
				kept_color = {3{CHAN_MAX}};
			for (k = 0; k < 3; k++) begin
				t = int'(cfg_target[k]);
				if (!(chan_dist(t, int'(px[k])) < chan_dist(int'(kept_color[k]), t)))
					nearer = 1'b0;
			end
			if (nearer)
				kept_color = px;
			return 1'b0;
		end
		in_band = 1'b1;
		match = 1'b1;
		for (k = 0; k < 3; k++) begin
			hi = (int'(bg[k]) <= 255 - int'(cfg_margin)) ? int'(bg[k]) + int'(cfg_margin) : 255;
			lo = (int'(bg[k]) >= int'(cfg_margin)) ? int'(bg[k]) - int'(cfg_margin) : 0;
			if (!(int'(px[k]) < hi && int'(px[k]) > lo))
				in_band = 1'b0;
			lim = (int'(kept_color[k]) * int'(cfg_percent)) / 100;
			if (!(chan_dist(int'(kept_color[k]), int'(px[k])) < lim))
				match = 1'b0;
		end
		mask = !in_band && match;
		return 1'b1;
	endfunction

	function automatic rgb_t rand_rgb();
		return rgb_t'($urandom);
	endfunction

	function automatic rgb_t jitter_rgb(input rgb_t c, input int spread);
		rgb_t r;
		int   k, v;
		for (k = 0; k < 3; k++) begin
			v = int'(c[k]) + int'($urandom_range(0, 2 * spread)) - spread;
			r[k] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : chan_t'(v);
		end
		return r;
	endfunction

	task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		if (wr) begin
			case (idx)
				REG_TARGET:  cfg_target = wdata[23:0];
				REG_MARGIN:  cfg_margin = wdata[7:0];
				REG_PERCENT: cfg_percent = wdata[6:0];
				default: ;
			endcase
		end
		psel <= 1'b0;
		penable <= 1'b0;
		// idle between transfers
		@(posedge clk);
	endtask

	// Write all registers, then read each one back.
	task automatic set_registers(input logic [31:0] tgt, input logic [31:0] margin,
			input logic [31:0] pct, input bit poke_unused);
		logic [31:0] rd;
		apb_access(1'b1, REG_TARGET, tgt, rd);
		apb_access(1'b1, REG_MARGIN, margin, rd);
		apb_access(1'b1, REG_PERCENT, pct, rd);
		if (poke_unused)
			apb_access(1'b1, REG_UNUSED, $urandom, rd);
		apb_access(1'b0, REG_TARGET, '0, rd);
		if (rd !== {8'h00, cfg_target})
			report_mismatch("target_color readback", int'(rd), int'(cfg_target));
		apb_access(1'b0, REG_MARGIN, '0, rd);
		if (rd !== {24'h0, cfg_margin})
			report_mismatch("band_margin readback", int'(rd), int'(cfg_margin));
		apb_access(1'b0, REG_PERCENT, '0, rd);
		if (rd !== {25'h0, cfg_percent})
			report_mismatch("match_percent readback", int'(rd), int'(cfg_percent));
	endtask

	task automatic send_pixel(input logic kind, input logic fs, input rgb_t px, input rgb_t bg,
			input bit typed, input logic typed_mask);
		logic m;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {bg, px};
		s_tuser <= {fs, kind};
		do @(posedge clk); while (!s_tready);
		if (predict_mask(kind, fs, px, bg, m))
			mask_q.push_back(typed ? typed_mask : m);
		words_sent++;
	endtask

	// Hold the sender until every mask word is out and the pipe is empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (mask_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic send_noise();
		send_pixel(logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
			rand_rgb(), rand_rgb(), 1'b0, 1'b0);
	endtask

	task automatic run_frame(input int n);
		rgb_t pix [32];
		rgb_t cluster;
		rgb_t bgv;
		int   i, r, m;
		logic fs;
		cluster = rand_rgb();
		for (i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 45)
				pix[i] = jitter_rgb(cfg_target, 16);
			else if (r < 75)
				pix[i] = jitter_rgb(cluster, 10);
			else
				pix[i] = rand_rgb();
		end
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < 6)
				send_noise();
			// drop frame start now and then, and raise it mid-frame now and then
			fs = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
			send_pixel(KIND_SCAN, fs, pix[i], rand_rgb(), 1'b0, 1'b0);
		end
		m = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : n;
		for (i = 0; i < m; i++) begin
			r = $urandom_range(0, 99);
			if (r < 35)
				bgv = jitter_rgb(pix[i], int'(cfg_margin) + 2);
			else if (r < 55)
				bgv = pix[i];
			else if (r < 70)
				bgv = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h000000;
			else
				bgv = rand_rgb();
			if ($urandom_range(0, 99) < 6)
				send_noise();
			send_pixel(KIND_CLASSIFY, logic'($urandom_range(0, 1)), pix[i], bgv, 1'b0, 1'b0);
		end
	endtask

	task automatic run_phase(input int count);
		int start;
		start = words_sent;
		while (words_sent - start < count)
			run_frame(($urandom_range(0, 9) == 0) ? 32 : $urandom_range(1, 12));
	endtask

	always @(posedge clk) begin
		if (rx_stall > 0) begin
			m_tready <= 1'b0;
			rx_stall--;
		end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
			m_tready <= 1'b0;
			rx_stall = $urandom_range(1, 16) - 1;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (mask_q.size() == 0) begin
				report_mismatch("mask word with none expected", int'(m_tdata[0]), 0);
			end else begin
				mask_want = mask_q.pop_front();
				if (m_tdata[0] !== mask_want)
					report_mismatch("mask_white", int'(m_tdata[0]), int'(mask_want));
			end
		end
	end

	initial begin
		int i;
		kept_color = {3{CHAN_MAX}};
		cfg_target = TARGET_RST;
		cfg_margin = MARGIN_RST;
		cfg_percent = PERCENT_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		tx_idle_pct = 30;
		rx_idle_pct = 5;
		for (i = 0; i < $size(pixel_rows); i++)
			send_pixel(pixel_rows[i].kind, pixel_rows[i].fs, pixel_rows[i].px,
				pixel_rows[i].bg, pixel_rows[i].typed, pixel_rows[i].mask);
		settle();

		set_registers(32'h0, 32'h0, 32'h0, 1'b0);
		tx_idle_pct = 25;
		rx_idle_pct = 6;
		run_phase(260);
		settle();

		set_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		tx_idle_pct = 10;
		rx_idle_pct = 10;
		run_phase(260);
		settle();

		set_registers($urandom, 32'd20, 32'd100, 1'b1);
		tx_idle_pct = 40;
		rx_idle_pct = 3;
		run_phase(260);
		settle();

		// a stretch with no idling on either side
		set_registers($urandom, $urandom_range(0, 64), $urandom_range(10, 60), 1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(260);
		settle();

		set_registers($urandom, $urandom, $urandom, 1'b1);
		tx_idle_pct = 20;
		rx_idle_pct = 8;
		run_phase(260);
		settle();

		set_registers($urandom, $urandom_range(0, 40), $urandom_range(20, 127), 1'b0);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_phase(150);

		settle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+src
src/bcm_pkg.sv
src/bcm_regs.sv
src/bcm_scan.sv
src/bcm_classify.sv
src/background_and_color_mask_unit.sv
dv/background_and_color_mask_unit_tb.sv
